@@ rtl/pap_pkg.sv @@
// ----------------------------------------------------------------------------
// pap_pkg
// shared types and constants of the proximity axis protection pipeline
// ----------------------------------------------------------------------------
package pap_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [9:0] AXIS_CENTER  = 10'd511;
    localparam logic [9:0] AXIS_MAX     = 10'd1022;
    localparam logic [9:0] PERMILLE_DEN = 10'd1000;

    localparam logic [7:0] RST_PROT_DIST = 8'd30;
    localparam logic [7:0] RST_LOW_BAND  = 8'd10;
    localparam logic [7:0] RST_MED_BAND  = 8'd30;
    localparam logic [9:0] RST_LOW_PM    = 10'd200;
    localparam logic [9:0] RST_MED_PM    = 10'd600;
    localparam logic [9:0] RST_HIGH_PM   = 10'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROT_DIST = 3'd0,
        CFG_LOW_BAND  = 3'd1,
        CFG_MED_BAND  = 3'd2,
        CFG_LOW_PM    = 3'd3,
        CFG_MED_PM    = 3'd4,
        CFG_HIGH_PM   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0] range_first;
        logic [9:0] range_second;
        logic [9:0] control_signal;
    } t_req;

    typedef struct packed {
        logic [9:0] axis_value;
        logic       danger_first;
        logic       danger_second;
    } t_rsp;

    typedef struct packed {
        logic [7:0] prot_dist;
        logic [7:0] low_band;
        logic [7:0] med_band;
        logic [9:0] low_pm;
        logic [9:0] med_pm;
        logic [9:0] high_pm;
    } t_cfg;

    // decoded band of one side
    typedef struct packed {
        logic [7:0] num;
        logic [7:0] den;
        logic [9:0] pm;
        logic [9:0] scale;
        logic       danger;
        logic       zero;
    } t_side_op;

    // per item data that rides along the divider stages
    typedef struct packed {
        logic [9:0] ctl;
        logic [9:0] scale1;
        logic [9:0] scale2;
        logic [9:0] pm1;
        logic [9:0] pm2;
        logic       danger1;
        logic       danger2;
        logic       zero1;
        logic       zero2;
    } t_item_info;

endpackage

@@ rtl/pap_div.sv @@
// ----------------------------------------------------------------------------
// pap_div
// restoring divider, one quotient bit per register stage, gives
// floor(rem * 2^FRAC_BITS / den) for rem < 2 * den
// ----------------------------------------------------------------------------
module pap_div
    import pap_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic [9:0]           i_rem,
    input  logic [9:0]           i_den,
    output logic [FRAC_BITS:0]   o_quo
);

    localparam int NS = FRAC_BITS + 1;

    logic [9:0]         r_rem [NS];
    logic [9:0]         r_den [NS];
    logic [FRAC_BITS:0] r_quo [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [10:0]        w_sh;
        logic [9:0]         w_den_in;
        logic [FRAC_BITS:0] w_quo_in;
        logic               w_ge;
        logic [10:0]        w_diff;
        logic [9:0]         n_rem;
        logic [FRAC_BITS:0] n_quo;

        if (k == 0) begin : g_head
            assign w_sh     = {1'b0, i_rem};
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_body
            assign w_sh     = {r_rem[k-1], 1'b0};
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_ge   = w_sh >= {1'b0, w_den_in};
        assign w_diff = w_sh - {1'b0, w_den_in};
        assign n_rem  = w_ge ? w_diff[9:0] : w_sh[9:0];

        always_comb begin
            n_quo                = w_quo_in;
            n_quo[FRAC_BITS - k] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_den[k] <= w_den_in;
            r_quo[k] <= n_quo;
        end
    end

    assign o_quo = r_quo[NS-1];

endmodule

@@ rtl/pap_front.sv @@
// ----------------------------------------------------------------------------
// pap_front
// input stage: deflection and band decode of both sides
// ----------------------------------------------------------------------------
module pap_front
    import pap_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_req      i_req,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_side_op  o_op1,
    output t_side_op  o_op2,
    output logic [9:0] o_ctl
);

    function automatic t_side_op decode_side(
        input logic [9:0] range_in,
        input logic [9:0] defl,
        input t_cfg       cfg
    );
        t_side_op   op;
        logic [9:0] tm;
        logic [9:0] tl;
        logic [9:0] tt;
        logic [9:0] diff;
        op     = '0;
        tt     = {2'b00, cfg.prot_dist};
        tm     = tt + {2'b00, cfg.med_band};
        tl     = tt + {2'b00, cfg.low_band};
        diff   = '0;
        op.pm    = cfg.low_pm;
        op.scale = defl;
        priority if (range_in >= tm) begin
            op.zero = 1'b1;
        end else if (range_in >= tl) begin
            diff   = tm - range_in;
            op.num = diff[7:0];
            op.den = cfg.med_band - cfg.low_band;
        end else if (range_in >= tt) begin
            diff   = tl - range_in;
            op.num = diff[7:0];
            op.den = cfg.low_band;
            op.pm  = cfg.med_pm;
        end else begin
            diff      = tt - range_in;
            op.num    = diff[7:0];
            op.den    = cfg.prot_dist;
            op.pm     = cfg.high_pm;
            op.scale  = AXIS_CENTER;
            op.danger = 1'b1;
        end
        if (op.den == 8'd0) begin
            op.zero = 1'b1;
        end
        return op;
    endfunction

    logic [9:0] w_defl;
    t_side_op   n_op1;
    t_side_op   n_op2;
    logic       r_valid;
    t_side_op   r_op1;
    t_side_op   r_op2;
    logic [9:0] r_ctl;

    assign w_defl = (i_req.control_signal >= AXIS_CENTER) ?
                    (i_req.control_signal - AXIS_CENTER) :
                    (AXIS_CENTER - i_req.control_signal);

    assign n_op1 = decode_side(i_req.range_first, w_defl, i_cfg);
    assign n_op2 = decode_side(i_req.range_second, w_defl, i_cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op1 <= n_op1;
        r_op2 <= n_op2;
        r_ctl <= i_req.control_signal;
    end

    assign o_valid = r_valid;
    assign o_op1   = r_op1;
    assign o_op2   = r_op2;
    assign o_ctl   = r_ctl;

endmodule

@@ rtl/pap_back.sv @@
// ----------------------------------------------------------------------------
// pap_back
// back end: gain times correction, times scale, then combine and saturate
// ----------------------------------------------------------------------------
module pap_back
    import pap_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item_info         i_info,
    input  logic [FRAC_BITS:0] i_gain1,
    input  logic [FRAC_BITS:0] i_gain2,
    input  logic [FRAC_BITS:0] i_corr1,
    input  logic [FRAC_BITS:0] i_corr2,
    output logic               o_valid,
    output t_rsp               o_rsp
);

    localparam int FW = FRAC_BITS + 2;
    localparam int PW = 2 * FRAC_BITS + 3;
    localparam int QW = FRAC_BITS + 12;

    function automatic logic [FW-1:0] mul_corr(
        input logic [FRAC_BITS:0] gain,
        input logic [FRAC_BITS:0] corr,
        input logic               danger,
        input logic               zero
    );
        logic [FW-1:0] corr_tot;
        logic [PW-1:0] prod;
        corr_tot = {1'b0, corr} + {1'b0, danger, {FRAC_BITS{1'b0}}};
        prod     = {{(FRAC_BITS+2){1'b0}}, gain} * {{(FRAC_BITS+1){1'b0}}, corr_tot};
        return zero ? '0 : prod[2*FRAC_BITS+1:FRAC_BITS];
    endfunction

    function automatic logic [10:0] mul_scale(
        input logic [FW-1:0] frac,
        input logic [9:0]    scale
    );
        logic [QW-1:0] prod;
        prod = {10'd0, frac} * {{FW{1'b0}}, scale};
        return prod[FRAC_BITS+10:FRAC_BITS];
    endfunction

    // multiply stage one
    logic          r_m1_valid;
    t_item_info    r_m1_info;
    logic [FW-1:0] r_frac1;
    logic [FW-1:0] r_frac2;

    // multiply stage two
    logic          r_m2_valid;
    t_item_info    r_m2_info;
    logic [10:0]   r_opp1;
    logic [10:0]   r_opp2;

    // output stage
    logic          r_out_valid;
    t_rsp          r_rsp;
    t_rsp          n_rsp;

    logic signed [12:0] w_v;
    logic signed [12:0] w_o1;
    logic signed [12:0] w_o2;
    logic signed [12:0] w_ctl;
    logic signed [12:0] w_ctr;
    logic [11:0]        w_o1_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid  <= 1'b0;
            r_m2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_m1_valid  <= i_valid;
            r_m2_valid  <= r_m1_valid;
            r_out_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_info <= i_info;
        r_frac1   <= mul_corr(i_gain1, i_corr1, i_info.danger1, i_info.zero1);
        r_frac2   <= mul_corr(i_gain2, i_corr2, i_info.danger2, i_info.zero2);
        r_m2_info <= r_m1_info;
        r_opp1    <= mul_scale(r_frac1, r_m1_info.scale1);
        r_opp2    <= mul_scale(r_frac2, r_m1_info.scale2);
        r_rsp     <= n_rsp;
    end

    assign w_o1     = $signed({2'b00, r_opp1});
    assign w_o2     = $signed({2'b00, r_opp2});
    assign w_ctl    = $signed({3'b000, r_m2_info.ctl});
    assign w_ctr    = $signed({3'b000, AXIS_CENTER});
    assign w_o1_rnd = {1'b0, r_opp1} + 12'd3;

    always_comb begin
        priority if (r_m2_info.danger1 && r_m2_info.danger2) begin
            w_v = w_ctr - $signed({3'b000, w_o1_rnd[11:2]})
                        + $signed({4'b0000, r_opp2[10:2]});
        end else if (r_m2_info.danger1) begin
            w_v = w_ctr - w_o1;
        end else if (r_m2_info.danger2) begin
            w_v = w_ctr + w_o2;
        end else if (r_m2_info.ctl >= AXIS_CENTER) begin
            w_v = w_ctl - w_o1;
        end else begin
            w_v = w_ctl + w_o2;
        end
    end

    always_comb begin
        n_rsp.danger_first  = r_m2_info.danger1;
        n_rsp.danger_second = r_m2_info.danger2;
        priority if (w_v < 13'sd0) begin
            n_rsp.axis_value = '0;
        end else if (w_v > $signed({3'b000, AXIS_MAX})) begin
            n_rsp.axis_value = AXIS_MAX;
        end else begin
            n_rsp.axis_value = w_v[9:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

@@ rtl/proximity_axis_protection.sv @@
// a request passes the front register, the divider stages and the back-end multiply and output stages before o_done
// throughput: one request per cycle; the divider stages, one quotient bit each,
// set the depth of the pipeline
// busy stays low, results come out in request order and cannot be stalled
// synchronous active-low reset clears the valid bits and loads register defaults
// ----------------------------------------------------------------------------
// proximity_axis_protection
// guards one stick axis with two opposing range readings
// ----------------------------------------------------------------------------
module proximity_axis_protection
    import pap_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output t_rsp                  o_rsp
);

    localparam int NS  = FRAC_BITS + 1;
    localparam int LAT = FRAC_BITS + 5;

    // reciprocal of 1000, exact floor for every 10-bit per-mille value
    localparam int CORR_SH = 20;
    localparam logic [FRAC_BITS+10:0] CORR_MUL = (FRAC_BITS+11)'(
        ((64'd1 << (FRAC_BITS + CORR_SH)) + 64'(PERMILLE_DEN) - 64'd1) / 64'(PERMILLE_DEN));

    function automatic logic [FRAC_BITS:0] permille_q(input logic [9:0] pm);
        logic [FRAC_BITS+CORR_SH:0] prod;
        prod = {{(FRAC_BITS+11){1'b0}}, pm} * {10'd0, CORR_MUL};
        return prod[FRAC_BITS+CORR_SH:CORR_SH];
    endfunction

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prot_dist <= RST_PROT_DIST;
            r_cfg.low_band  <= RST_LOW_BAND;
            r_cfg.med_band  <= RST_MED_BAND;
            r_cfg.low_pm    <= RST_LOW_PM;
            r_cfg.med_pm    <= RST_MED_PM;
            r_cfg.high_pm   <= RST_HIGH_PM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROT_DIST: r_cfg.prot_dist <= i_cfg_data[7:0];
                CFG_LOW_BAND:  r_cfg.low_band  <= i_cfg_data[7:0];
                CFG_MED_BAND:  r_cfg.med_band  <= i_cfg_data[7:0];
                CFG_LOW_PM:    r_cfg.low_pm    <= i_cfg_data;
                CFG_MED_PM:    r_cfg.med_pm    <= i_cfg_data;
                CFG_HIGH_PM:   r_cfg.high_pm   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic       w_fr_valid;
    t_side_op   w_op1;
    t_side_op   w_op2;
    logic [9:0] w_ctl;

    pap_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .o_valid (w_fr_valid),
        .o_op1   (w_op1),
        .o_op2   (w_op2),
        .o_ctl   (w_ctl)
    );

    logic [FRAC_BITS:0] w_gain1;
    logic [FRAC_BITS:0] w_gain2;

    pap_div #(.FRAC_BITS(FRAC_BITS)) u_gain1 (
        .i_clk (i_clk),
        .i_rem ({2'b00, w_op1.num}),
        .i_den ({2'b00, w_op1.den}),
        .o_quo (w_gain1)
    );

    pap_div #(.FRAC_BITS(FRAC_BITS)) u_gain2 (
        .i_clk (i_clk),
        .i_rem ({2'b00, w_op2.num}),
        .i_den ({2'b00, w_op2.den}),
        .o_quo (w_gain2)
    );

    // side data aligned with the divider stages
    t_item_info         n_info;
    logic               r_dly_valid [NS];
    t_item_info         r_dly_info  [NS];
    logic [FRAC_BITS:0] r_corr1;
    logic [FRAC_BITS:0] r_corr2;

    always_comb begin
        n_info.ctl     = w_ctl;
        n_info.scale1  = w_op1.scale;
        n_info.scale2  = w_op2.scale;
        n_info.pm1     = w_op1.pm;
        n_info.pm2     = w_op2.pm;
        n_info.danger1 = w_op1.danger;
        n_info.danger2 = w_op2.danger;
        n_info.zero1   = w_op1.zero;
        n_info.zero2   = w_op2.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_dly_valid[k] <= 1'b0;
            end
        end else begin
            r_dly_valid[0] <= w_fr_valid;
            for (int k = 1; k < NS; k++) begin
                r_dly_valid[k] <= r_dly_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly_info[0] <= n_info;
        for (int k = 1; k < NS; k++) begin
            r_dly_info[k] <= r_dly_info[k-1];
        end
        r_corr1 <= permille_q(r_dly_info[NS-2].pm1);
        r_corr2 <= permille_q(r_dly_info[NS-2].pm2);
    end

    pap_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dly_valid[NS-1]),
        .i_info  (r_dly_info[NS-1]),
        .i_gain1 (w_gain1),
        .i_gain2 (w_gain2),
        .i_corr1 (r_corr1),
        .i_corr2 (r_corr2),
        .o_valid (o_done),
        .o_rsp   (o_rsp)
    );

    a_done_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without a request");

    a_axis_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.axis_value <= AXIS_MAX))
        else $error("axis value out of range");

    a_first_danger_pushes_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.danger_first && !o_rsp.danger_second)
            |-> (o_rsp.axis_value <= AXIS_CENTER))
        else $error("first side danger did not push back");

    a_second_danger_pushes_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.danger_second && !o_rsp.danger_first)
            |-> (o_rsp.axis_value >= AXIS_CENTER))
        else $error("second side danger did not push back");

endmodule
